>>> rtl/rcwt_pkg.sv
// Shared types and codes for the request credit window tracker.
package rcwt_pkg;

    // Entry tag codes
    localparam logic [1:0] TAG_FREE    = 2'd0;
    localparam logic [1:0] TAG_AVBL    = 2'd1;
    localparam logic [1:0] TAG_INUSE   = 2'd2;
    localparam logic [1:0] TAG_INTERIM = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_INVALID      = 3'd1;
    localparam logic [2:0] ST_INTERNAL     = 3'd2;
    localparam logic [2:0] ST_POOL_EMPTY   = 3'd3;
    localparam logic [2:0] ST_NO_RESOURCES = 3'd4;

    // Command codes
    localparam logic CMD_ACQUIRE = 1'b0;
    localparam logic CMD_RESPOND = 1'b1;

    // Register indexes
    localparam logic [2:0] REG_LIMIT = 3'd0;
    localparam logic [2:0] REG_START = 3'd1;
    localparam logic [2:0] REG_FLOOR = 3'd2;
    localparam logic [2:0] REG_POOL  = 3'd3;
    localparam logic [2:0] REG_RAMP  = 3'd4;

    // Datapath operation codes
    localparam logic [3:0] OP_NONE         = 4'd0;
    localparam logic [3:0] OP_CAPTURE      = 4'd1;
    localparam logic [3:0] OP_SCAN_START   = 4'd2;
    localparam logic [3:0] OP_SCAN_NEXT    = 4'd3;
    localparam logic [3:0] OP_CLEAR_WR     = 4'd4;
    localparam logic [3:0] OP_INIT_TAKE    = 4'd5;
    localparam logic [3:0] OP_ISSUE_WR     = 4'd6;
    localparam logic [3:0] OP_SET_INUSE    = 4'd7;
    localparam logic [3:0] OP_SET_FREE     = 4'd8;
    localparam logic [3:0] OP_RESP_HIT     = 4'd9;
    localparam logic [3:0] OP_ERR_INVALID  = 4'd10;
    localparam logic [3:0] OP_ERR_INTERNAL = 4'd11;
    localparam logic [3:0] OP_WANT         = 4'd12;
    localparam logic [3:0] OP_TAKE         = 4'd13;
    localparam logic [3:0] OP_FINISH       = 4'd14;

    localparam logic [63:0] SEQ_NONE = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [8:0]  credit_limit;
        logic [7:0]  credit_start;
        logic [8:0]  credit_floor;
        logic [15:0] global_pool_size;
        logic [7:0]  ramp_step;
    } cfg_t;

    typedef struct packed {
        logic [3:0] op;
    } cmd_t;

    typedef struct packed {
        logic [1:0] rd_tag;
        logic       seq_match;
        logic       addr_last;
        logic       issue_zero;
        logic       st_err;
        logic       is_respond;
        logic       is_async;
        logic       seq_none;
        logic       inited;
        logic       grant_go;
        logic       out_free;
    } stat_t;

endpackage

>>> rtl/request_credit_window_tracker_top.sv
// Top level of the request credit window tracker.
//
//  channel | direction | handshake          | contents
//  s_      | in        | s_tvalid/s_tready  | request word: sequence, credits, command, async
//  m_      | out       | m_tvalid/m_tready  | result word: status, credits granted
//  apb     | in        | psel/penable       | five configuration registers at 4*i
//
// Every store scan (lookup and lowest-free-slot issue) reads one entry of the RAM at a
// time and visits at most ENTRIES entries. A word runs up to four scans (floor issue on
// the first word, lookup, replacement issue for an async reply, grant issue).
// After reset a clearing pass marks every entry free; s_tready stays low during it.
// One word is in work at a time; the next is taken while the result word waits in the
// output register.
module request_credit_window_tracker_top #(
    parameter int ENTRIES = 512
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // sequence_req[63:0], credits_requested[79:64]
    input  logic [1:0]  s_tuser,   // command[0], is_async[1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // status[2:0], credits_granted[12:3], zero pad
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    rcwt_pkg::cfg_t  cfg;
    rcwt_pkg::cmd_t  cmd;
    rcwt_pkg::stat_t stat;

    rcwt_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rcwt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rcwt_datapath #(.ENTRIES(ENTRIES)) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );
endmodule

>>> rtl/rcwt_ram.sv
// Generic single-port-write, registered-read RAM.
module rcwt_ram #(
    parameter int WIDTH = 66,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/rcwt_regs.sv
// Configuration register file behind the APB-style port.
module rcwt_regs (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output rcwt_pkg::cfg_t cfg
);
    rcwt_pkg::cfg_t cfg_reg, cfg_next;
    logic [2:0] idx;

    assign idx    = paddr[4:2];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Decode a write
    always_comb begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite) begin
            unique case (idx)
                rcwt_pkg::REG_LIMIT: cfg_next.credit_limit     = pwdata[8:0];
                rcwt_pkg::REG_START: cfg_next.credit_start     = pwdata[7:0];
                rcwt_pkg::REG_FLOOR: cfg_next.credit_floor     = pwdata[8:0];
                rcwt_pkg::REG_POOL:  cfg_next.global_pool_size = pwdata[15:0];
                rcwt_pkg::REG_RAMP:  cfg_next.ramp_step        = pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (idx)
            rcwt_pkg::REG_LIMIT: prdata = 32'(cfg_reg.credit_limit);
            rcwt_pkg::REG_START: prdata = 32'(cfg_reg.credit_start);
            rcwt_pkg::REG_FLOOR: prdata = 32'(cfg_reg.credit_floor);
            rcwt_pkg::REG_POOL:  prdata = 32'(cfg_reg.global_pool_size);
            rcwt_pkg::REG_RAMP:  prdata = 32'(cfg_reg.ramp_step);
            default:             prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.credit_limit     <= 9'd256;
            cfg_reg.credit_start     <= 8'd16;
            cfg_reg.credit_floor     <= 9'd1;
            cfg_reg.global_pool_size <= 16'd1024;
            cfg_reg.ramp_step        <= 8'd8;
        end else begin
            cfg_reg <= cfg_next;
        end
    end
endmodule

>>> rtl/rcwt_datapath.sv
// Credit tracker datapath: entry store, counters, pool and result register.
module rcwt_datapath #(
    parameter int ENTRIES = 512
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  rcwt_pkg::cfg_t cfg,
    input  rcwt_pkg::cmd_t cmd,
    output rcwt_pkg::stat_t stat,
    input  logic [79:0]    s_tdata,
    input  logic [1:0]     s_tuser,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [15:0]    m_tdata
);
    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    // Item fields
    logic        cmd_reg, cmd_next;
    logic        async_reg, async_next;
    logic [63:0] seq_reg, seq_next;
    logic [15:0] req_reg, req_next;
    // Scan and bookkeeping
    logic [AW-1:0] addr_reg, addr_next;
    logic [CW-1:0] free_reg, free_next;
    logic [8:0]    issue_reg, issue_next;
    logic [63:0]   nseq_reg, nseq_next;
    logic [8:0]    total_reg, total_next;
    logic [15:0]   last_reg, last_next;
    logic [15:0]   pool_reg, pool_next;
    logic          init_reg, init_next;
    logic [2:0]    st_reg, st_next;
    logic [9:0]    granted_reg, granted_next;
    logic [8:0]    want_reg, want_next;
    logic          go_reg, go_next;
    // Result word
    logic          oval_reg, oval_next;
    logic [15:0]   odata_reg, odata_next;

    // Entry store
    logic          we;
    logic [65:0]   wdata, rdata;
    logic [1:0]    rd_tag;
    logic [63:0]   rd_seq;

    // Grant sizing
    logic [15:0] free16, floor16, req_eff, start16;
    logic [16:0] dbl, ramp_sum, want_a;
    logic [8:0]  got;

    rcwt_ram #(.WIDTH(66), .DEPTH(ENTRIES)) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (addr_reg),
        .wdata (wdata),
        .raddr (addr_reg),
        .rdata (rdata)
    );

    assign rd_tag  = rdata[65:64];
    assign rd_seq  = rdata[63:0];
    assign free16  = 16'(free_reg);
    assign floor16 = 16'(cfg.credit_floor);
    assign start16 = 16'(cfg.credit_start);
    assign req_eff = req_reg - 16'(granted_reg);
    assign dbl      = 17'(cfg.credit_start) << 1;
    assign ramp_sum = 17'(last_reg) + 17'(cfg.ramp_step);
    assign got      = (pool_reg >= 16'(want_reg)) ? want_reg : pool_reg[8:0];

    // Pick the ramp-rule grant before the limit cap
    always_comb begin
        if (req_eff < start16) begin
            want_a = 17'(req_eff);
        end else if (last_reg >= start16) begin
            want_a = (ramp_sum > dbl) ? dbl : ramp_sum;
        end else begin
            want_a = 17'(cfg.credit_start);
        end
    end

    assign stat.rd_tag     = rd_tag;
    assign stat.seq_match  = (rd_seq == seq_reg);
    assign stat.addr_last  = (addr_reg == AW'(ENTRIES - 1));
    assign stat.issue_zero = (issue_reg == 9'd0);
    assign stat.st_err     = (st_reg != rcwt_pkg::ST_OK);
    assign stat.is_respond = (cmd_reg == rcwt_pkg::CMD_RESPOND);
    assign stat.is_async   = async_reg;
    assign stat.seq_none   = (seq_reg == rcwt_pkg::SEQ_NONE);
    assign stat.inited     = init_reg;
    assign stat.grant_go   = go_reg;
    assign stat.out_free   = !oval_reg || m_tready;

    assign m_tvalid = oval_reg;
    assign m_tdata  = odata_reg;

    // Execute one operation per cycle
    always_comb begin
        cmd_next     = cmd_reg;
        async_next   = async_reg;
        seq_next     = seq_reg;
        req_next     = req_reg;
        addr_next    = addr_reg;
        free_next    = free_reg;
        issue_next   = issue_reg;
        nseq_next    = nseq_reg;
        total_next   = total_reg;
        last_next    = last_reg;
        pool_next    = pool_reg;
        init_next    = init_reg;
        st_next      = st_reg;
        granted_next = granted_reg;
        want_next    = want_reg;
        go_next      = go_reg;
        oval_next    = oval_reg && !m_tready;
        odata_next   = odata_reg;
        we           = 1'b0;
        wdata        = {rcwt_pkg::TAG_FREE, rd_seq};

        unique case (cmd.op)
            rcwt_pkg::OP_CAPTURE: begin
                seq_next     = s_tdata[63:0];
                req_next     = s_tdata[79:64];
                cmd_next     = s_tuser[0];
                async_next   = s_tuser[1];
                st_next      = rcwt_pkg::ST_OK;
                granted_next = 10'd0;
            end
            rcwt_pkg::OP_SCAN_START: addr_next = '0;
            rcwt_pkg::OP_SCAN_NEXT:  addr_next = addr_reg + AW'(1);
            rcwt_pkg::OP_CLEAR_WR: begin
                we        = 1'b1;
                wdata     = {rcwt_pkg::TAG_FREE, 64'd0};
                addr_next = addr_reg + AW'(1);
            end
            rcwt_pkg::OP_INIT_TAKE: begin
                // Load pool and take the floor, or fail and put it back
                if (cfg.global_pool_size == 16'd0) begin
                    pool_next = 16'd0;
                    st_next   = rcwt_pkg::ST_POOL_EMPTY;
                end else if (cfg.global_pool_size < floor16 || free16 < floor16) begin
                    pool_next = cfg.global_pool_size;
                    st_next   = rcwt_pkg::ST_NO_RESOURCES;
                end else begin
                    pool_next  = cfg.global_pool_size - floor16;
                    issue_next = cfg.credit_floor;
                    total_next = total_reg + cfg.credit_floor;
                    last_next  = floor16;
                    init_next  = 1'b1;
                end
            end
            rcwt_pkg::OP_ISSUE_WR: begin
                we         = 1'b1;
                wdata      = {rcwt_pkg::TAG_AVBL, nseq_reg};
                nseq_next  = nseq_reg + 64'd1;
                free_next  = free_reg - CW'(1);
                issue_next = issue_reg - 9'd1;
                addr_next  = addr_reg + AW'(1);
            end
            rcwt_pkg::OP_SET_INUSE: begin
                we    = 1'b1;
                wdata = {rcwt_pkg::TAG_INUSE, rd_seq};
            end
            rcwt_pkg::OP_SET_FREE: begin
                we        = 1'b1;
                wdata     = {rcwt_pkg::TAG_FREE, rd_seq};
                free_next = free_reg + CW'(1);
            end
            rcwt_pkg::OP_RESP_HIT: begin
                we = 1'b1;
                if (req_reg != 16'd0 || total_reg == cfg.credit_floor) begin
                    if (async_reg) begin
                        // Park in interim, then issue a replacement
                        wdata = {rcwt_pkg::TAG_INTERIM, rd_seq};
                        if (free_reg == '0) begin
                            st_next = rcwt_pkg::ST_NO_RESOURCES;
                        end else begin
                            issue_next   = 9'd1;
                            granted_next = 10'd1;
                        end
                    end else begin
                        // Reissue under a fresh sequence
                        wdata        = {rcwt_pkg::TAG_AVBL, nseq_reg};
                        nseq_next    = nseq_reg + 64'd1;
                        granted_next = 10'd1;
                    end
                end else begin
                    // Return the credit to the pool
                    if (async_reg) begin
                        wdata = {rcwt_pkg::TAG_INTERIM, rd_seq};
                    end else begin
                        wdata     = {rcwt_pkg::TAG_FREE, rd_seq};
                        free_next = free_reg + CW'(1);
                    end
                    if (total_reg != 9'd0) begin
                        total_next = total_reg - 9'd1;
                    end
                    if (pool_reg != 16'hFFFF) begin
                        pool_next = pool_reg + 16'd1;
                    end
                end
            end
            rcwt_pkg::OP_ERR_INVALID:  st_next = rcwt_pkg::ST_INVALID;
            rcwt_pkg::OP_ERR_INTERNAL: st_next = rcwt_pkg::ST_INTERNAL;
            rcwt_pkg::OP_WANT: begin
                go_next = (req_reg > 16'(granted_reg)) && (cfg.credit_limit > total_reg);
                if (want_a + 17'(total_reg) > 17'(cfg.credit_limit)) begin
                    want_next = cfg.credit_limit - total_reg;
                end else begin
                    want_next = want_a[8:0];
                end
            end
            rcwt_pkg::OP_TAKE: begin
                if (pool_reg == 16'd0) begin
                    st_next = rcwt_pkg::ST_POOL_EMPTY;
                end else if (free16 < 16'(got)) begin
                    st_next = rcwt_pkg::ST_NO_RESOURCES;
                end else begin
                    pool_next    = pool_reg - 16'(got);
                    issue_next   = got;
                    total_next   = total_reg + got;
                    granted_next = granted_reg + 10'(got);
                end
            end
            rcwt_pkg::OP_FINISH: begin
                oval_next = 1'b1;
                if (st_reg == rcwt_pkg::ST_OK) begin
                    odata_next = {3'd0, granted_reg, st_reg};
                end else begin
                    odata_next = {3'd0, 10'd0, st_reg};
                end
                if (cmd_reg == rcwt_pkg::CMD_RESPOND) begin
                    last_next = 16'(granted_reg);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg  <= '0;
            free_reg  <= CW'(ENTRIES);
            issue_reg <= 9'd0;
            nseq_reg  <= 64'd0;
            total_reg <= 9'd0;
            last_reg  <= 16'd0;
            pool_reg  <= 16'd0;
            init_reg  <= 1'b0;
            st_reg    <= rcwt_pkg::ST_OK;
            go_reg    <= 1'b0;
            oval_reg  <= 1'b0;
        end else begin
            addr_reg  <= addr_next;
            free_reg  <= free_next;
            issue_reg <= issue_next;
            nseq_reg  <= nseq_next;
            total_reg <= total_next;
            last_reg  <= last_next;
            pool_reg  <= pool_next;
            init_reg  <= init_next;
            st_reg    <= st_next;
            go_reg    <= go_next;
            oval_reg  <= oval_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        async_reg   <= async_next;
        seq_reg     <= seq_next;
        req_reg     <= req_next;
        granted_reg <= granted_next;
        want_reg    <= want_next;
        odata_reg   <= odata_next;
    end
endmodule

>>> rtl/rcwt_ctrl.sv
// Credit tracker sequencer: walks the entry store and orders the datapath steps.
module rcwt_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  rcwt_pkg::stat_t stat,
    output rcwt_pkg::cmd_t  cmd
);
    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_DISPATCH = 4'd2;
    localparam logic [3:0] S_INIT_CHK = 4'd3;
    localparam logic [3:0] S_F_START  = 4'd4;
    localparam logic [3:0] S_F_RD     = 4'd5;
    localparam logic [3:0] S_F_CHK    = 4'd6;
    localparam logic [3:0] S_HIT_CHK  = 4'd7;
    localparam logic [3:0] S_GRANT    = 4'd8;
    localparam logic [3:0] S_GR_CHK   = 4'd9;
    localparam logic [3:0] S_TAKE_CHK = 4'd10;
    localparam logic [3:0] S_IS_RD    = 4'd11;
    localparam logic [3:0] S_IS_CHK   = 4'd12;
    localparam logic [3:0] S_DONE     = 4'd13;

    localparam logic [1:0] R_FIND  = 2'd0;
    localparam logic [1:0] R_GRANT = 2'd1;
    localparam logic [1:0] R_DONE  = 2'd2;

    logic [3:0] state_reg, state_next;
    logic [1:0] ret_reg, ret_next;
    logic [1:0] target_reg, target_next;
    logic       hit;

    assign s_tready = (state_reg == S_IDLE);
    assign hit      = (stat.rd_tag == target_reg) && stat.seq_match;

    always_comb begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        target_next = target_reg;
        cmd.op      = rcwt_pkg::OP_NONE;
        unique case (state_reg)
            S_CLEAR: begin
                // Sweep the store to free after reset
                cmd.op = rcwt_pkg::OP_CLEAR_WR;
                if (stat.addr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = rcwt_pkg::OP_CAPTURE;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                target_next = stat.is_respond ? rcwt_pkg::TAG_INUSE : rcwt_pkg::TAG_AVBL;
                if (stat.seq_none) begin
                    state_next = S_DONE;
                end else if (!stat.inited) begin
                    cmd.op     = rcwt_pkg::OP_INIT_TAKE;
                    state_next = S_INIT_CHK;
                end else begin
                    state_next = S_F_START;
                end
            end
            S_INIT_CHK: begin
                if (stat.st_err) begin
                    state_next = S_DONE;
                end else begin
                    cmd.op     = rcwt_pkg::OP_SCAN_START;
                    ret_next   = R_FIND;
                    state_next = S_IS_RD;
                end
            end
            S_F_START: begin
                cmd.op     = rcwt_pkg::OP_SCAN_START;
                state_next = S_F_RD;
            end
            S_F_RD: state_next = S_F_CHK;
            S_F_CHK: begin
                // Search for the sequence under the target tag
                if (hit) begin
                    if (!stat.is_respond) begin
                        cmd.op     = rcwt_pkg::OP_SET_INUSE;
                        state_next = S_DONE;
                    end else if (target_reg == rcwt_pkg::TAG_INUSE) begin
                        cmd.op     = rcwt_pkg::OP_RESP_HIT;
                        state_next = S_HIT_CHK;
                    end else begin
                        cmd.op     = rcwt_pkg::OP_SET_FREE;
                        state_next = S_DONE;
                    end
                end else if (stat.addr_last) begin
                    if (!stat.is_respond) begin
                        cmd.op     = rcwt_pkg::OP_ERR_INVALID;
                        state_next = S_DONE;
                    end else if (stat.is_async && target_reg == rcwt_pkg::TAG_INUSE) begin
                        target_next = rcwt_pkg::TAG_INTERIM;
                        state_next  = S_F_START;
                    end else begin
                        cmd.op     = rcwt_pkg::OP_ERR_INTERNAL;
                        state_next = S_DONE;
                    end
                end else begin
                    cmd.op     = rcwt_pkg::OP_SCAN_NEXT;
                    state_next = S_F_RD;
                end
            end
            S_HIT_CHK: begin
                if (stat.st_err) begin
                    state_next = S_DONE;
                end else begin
                    cmd.op     = rcwt_pkg::OP_SCAN_START;
                    ret_next   = R_GRANT;
                    state_next = S_IS_RD;
                end
            end
            S_GRANT: begin
                cmd.op     = rcwt_pkg::OP_WANT;
                state_next = S_GR_CHK;
            end
            S_GR_CHK: begin
                if (stat.grant_go) begin
                    cmd.op     = rcwt_pkg::OP_TAKE;
                    state_next = S_TAKE_CHK;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_TAKE_CHK: begin
                if (stat.st_err) begin
                    state_next = S_DONE;
                end else begin
                    cmd.op     = rcwt_pkg::OP_SCAN_START;
                    ret_next   = R_DONE;
                    state_next = S_IS_RD;
                end
            end
            S_IS_RD: begin
                // Leave once every pending credit has a slot
                if (stat.issue_zero) begin
                    unique case (ret_reg)
                        R_FIND:  state_next = S_F_START;
                        R_GRANT: state_next = S_GRANT;
                        default: state_next = S_DONE;
                    endcase
                end else begin
                    state_next = S_IS_CHK;
                end
            end
            S_IS_CHK: begin
                cmd.op = (stat.rd_tag == rcwt_pkg::TAG_FREE) ? rcwt_pkg::OP_ISSUE_WR
                                                              : rcwt_pkg::OP_SCAN_NEXT;
                state_next = S_IS_RD;
            end
            S_DONE: begin
                if (stat.out_free) begin
                    cmd.op     = rcwt_pkg::OP_FINISH;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_CLEAR;
            ret_reg    <= R_DONE;
            target_reg <= rcwt_pkg::TAG_FREE;
        end else begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            target_reg <= target_next;
        end
    end
endmodule
